@@ design/smpre_pkg.sv @@
// Package for the sparse matrix product row engine.
// Holds sizes, action codes, register index codes and the controller state type; no dependencies.
package smpre_pkg;

  localparam int InnerRows  = 1024;
  localparam int OutColumns = 1024;
  localparam int MaxPerRow  = 8;
  localparam int TouchDepth = MaxPerRow * MaxPerRow;
  localparam int StoreDepth = InnerRows * MaxPerRow;

  localparam int IdxW   = 10;
  localparam int SlotW  = 3;
  localparam int ColW   = 10;
  localparam int ValW   = 16;
  localparam int AccW   = 38;
  localparam int CntW   = 21;
  localparam int CfgW   = 21;
  localparam int StoreAw = $clog2(StoreDepth);
  localparam int ColAw  = $clog2(OutColumns);
  localparam int TouchAw = $clog2(TouchDepth);
  localparam int TouchCw = TouchAw + 1;
  localparam int FanW   = $clog2(MaxPerRow) + 1;

  typedef enum logic [1:0] {
    ActLoad  = 2'd0,
    ActLeft  = 2'd1,
    ActStart = 2'd2,
    ActNone  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    RegAPerRow = 2'd0,
    RegBPerRow = 2'd1,
    RegCap     = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    StInit,
    StIdle,
    StFanRead,
    StFanAcc,
    StFanWrite,
    StGatherRead,
    StGatherWait,
    StOut,
    StClearRead,
    StClear
  } state_t;

endpackage

@@ design/sparse_matrix_product_row_engine_top.sv @@
// Top level of the sparse matrix product row engine.
// Depends on smpre_pkg for sizes, action codes and the state type.
//
// One item is taken at a time. After reset a clearing pass writes zero to
// every accumulator entry and its live flag, with in_ready low. A start beat
// clears the sums and live flags of the columns touched by an abandoned
// partial row. For a left entry, each right entry is one store read, one
// accumulator read and one accumulator write, all through synchronous
// memories. A row end then emits a result for each touched column, waiting
// out any output stalls, and clears their sums and live flags.
module sparse_matrix_product_row_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [smpre_pkg::CfgW-1:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [smpre_pkg::IdxW-1:0]  inner_index,
  input  logic [smpre_pkg::SlotW-1:0] slot,
  input  logic [smpre_pkg::ColW-1:0]  entry_column,
  input  logic signed [smpre_pkg::ValW-1:0] entry_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [smpre_pkg::ColW-1:0]  out_column,
  output logic signed [smpre_pkg::AccW-1:0] out_value,
  output logic        kept,
  output logic        last_of_row,
  output logic [smpre_pkg::CntW-1:0]  nnz_total,
  output logic        overflow_flag
);

  logic [3:0] a_per_row, b_per_row;
  logic [smpre_pkg::CntW-1:0] out_capacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_per_row    <= 4'd8;
      b_per_row    <= 4'd8;
      out_capacity <= smpre_pkg::CntW'(1048576);
    end else if (cfg_we) begin
      unique case (cfg_index)
        smpre_pkg::RegAPerRow: a_per_row <= cfg_data[3:0];
        smpre_pkg::RegBPerRow: b_per_row <= cfg_data[3:0];
        smpre_pkg::RegCap:     out_capacity <= cfg_data[smpre_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  // Memories.
  logic [smpre_pkg::ColW+smpre_pkg::ValW-1:0] store_mem [smpre_pkg::StoreDepth];
  logic [smpre_pkg::AccW:0] acc_mem [smpre_pkg::OutColumns]; // {live, sum}
  logic [smpre_pkg::ColW-1:0] touch_mem [smpre_pkg::TouchDepth];

  smpre_pkg::state_t state, state_next;
  logic [smpre_pkg::IdxW-1:0] cur_inner;
  logic signed [smpre_pkg::ValW-1:0] cur_value;
  logic [smpre_pkg::FanW-1:0] fan;
  logic [smpre_pkg::FanW-1:0] b_eff;
  logic [smpre_pkg::FanW-1:0] a_eff;
  logic [3:0] entries_in_row;
  logic [smpre_pkg::TouchCw-1:0] touched_count, scan;
  logic [smpre_pkg::CntW-1:0] stored_count;
  logic overflow_seen;
  logic [smpre_pkg::ColAw-1:0] init_addr;

  logic [smpre_pkg::ColW+smpre_pkg::ValW-1:0] store_rd;
  logic [smpre_pkg::AccW:0] acc_rd;
  logic [smpre_pkg::ColW-1:0] touch_rd;
  logic [smpre_pkg::ColW-1:0] jc;
  logic signed [smpre_pkg::ValW-1:0] rv;
  logic signed [2*smpre_pkg::ValW-1:0] prod;

  always_comb begin
    b_eff = (b_per_row > 4'd8) ? smpre_pkg::FanW'(smpre_pkg::MaxPerRow)
                               : smpre_pkg::FanW'(b_per_row);
    a_eff = (a_per_row > 4'd8) ? smpre_pkg::FanW'(smpre_pkg::MaxPerRow)
          : (a_per_row == 4'd0) ? smpre_pkg::FanW'(1) : smpre_pkg::FanW'(a_per_row);
  end

  logic accept;
  assign in_ready = (state == smpre_pkg::StIdle);
  assign accept   = in_valid && in_ready;

  // Store memory: written on load beats, read during fan-out.
  logic [smpre_pkg::StoreAw-1:0] store_ra;
  assign store_ra = {cur_inner, fan[smpre_pkg::FanW-2:0]};
  always_ff @(posedge clk) begin
    if (accept && smpre_pkg::action_t'(action) == smpre_pkg::ActLoad)
      store_mem[{inner_index, slot}] <= {entry_column, entry_value};
    store_rd <= store_mem[store_ra];
  end

  // The top bit of each accumulator entry is its live flag. The clearing pass
  // after reset zeroes every entry; a row end zeroes only the touched ones.
  logic acc_we;
  logic [smpre_pkg::ColAw-1:0] acc_wa, acc_ra;
  logic [smpre_pkg::AccW:0] acc_wd;
  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_wa] <= acc_wd;
    acc_rd <= acc_mem[acc_ra];
  end

  logic touch_we;
  always_ff @(posedge clk) begin
    if (touch_we) touch_mem[touched_count[smpre_pkg::TouchAw-1:0]] <= jc;
    touch_rd <= touch_mem[scan[smpre_pkg::TouchAw-1:0]];
  end

  logic live_j;
  assign live_j = acc_rd[smpre_pkg::AccW];

  logic [smpre_pkg::AccW-1:0] sum_new;
  always_comb begin
    sum_new = live_j ? acc_rd[smpre_pkg::AccW-1:0] + smpre_pkg::AccW'(prod)
                     : smpre_pkg::AccW'(prod);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      smpre_pkg::StInit:
        if (init_addr == smpre_pkg::ColAw'(smpre_pkg::OutColumns - 1))
          state_next = smpre_pkg::StIdle;
      smpre_pkg::StIdle:
        if (accept) begin
          priority case (smpre_pkg::action_t'(action))
            smpre_pkg::ActLeft:  state_next = smpre_pkg::StFanRead;
            smpre_pkg::ActStart: state_next = smpre_pkg::StClearRead;
            default:             state_next = smpre_pkg::StIdle;
          endcase
        end
      smpre_pkg::StFanRead:
        if (fan >= b_eff) begin
          state_next = (entries_in_row + 4'd1 >= 4'(a_eff))
                       ? smpre_pkg::StGatherRead : smpre_pkg::StIdle;
        end else begin
          state_next = smpre_pkg::StFanAcc;
        end
      smpre_pkg::StFanAcc:   state_next = smpre_pkg::StFanWrite;
      smpre_pkg::StFanWrite: state_next = smpre_pkg::StFanRead;
      smpre_pkg::StGatherRead:
        state_next = (scan >= touched_count) ? smpre_pkg::StClearRead
                                             : smpre_pkg::StGatherWait;
      smpre_pkg::StGatherWait: state_next = smpre_pkg::StOut;
      smpre_pkg::StOut:
        if (out_ready) state_next = smpre_pkg::StGatherRead;
      smpre_pkg::StClearRead:
        state_next = (scan >= touched_count) ? smpre_pkg::StIdle : smpre_pkg::StClear;
      smpre_pkg::StClear: state_next = smpre_pkg::StClearRead;
      default: state_next = smpre_pkg::StIdle;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    acc_we   = 1'b0;
    acc_wa   = jc;
    acc_ra   = jc;
    acc_wd   = {1'b1, sum_new};
    touch_we = 1'b0;
    out_valid = (state == smpre_pkg::StOut);
    unique case (state)
      smpre_pkg::StInit: begin
        acc_we = 1'b1;
        acc_wa = init_addr;
        acc_wd = '0;
      end
      smpre_pkg::StFanWrite: begin
        acc_we   = (live_j || touched_count < smpre_pkg::TouchCw'(smpre_pkg::TouchDepth));
        touch_we = !live_j && touched_count < smpre_pkg::TouchCw'(smpre_pkg::TouchDepth);
      end
      smpre_pkg::StGatherWait: acc_ra = touch_rd;
      smpre_pkg::StClear: begin
        acc_we = 1'b1;
        acc_wa = touch_rd;
        acc_wd = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == smpre_pkg::StFanAcc) prod <= cur_value * rv;
  end

  always_comb begin
    jc = store_rd[smpre_pkg::ValW +: smpre_pkg::ColW];
    rv = store_rd[smpre_pkg::ValW-1:0];
  end

  logic row_kept;
  assign row_kept = stored_count < out_capacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= smpre_pkg::StInit;
      init_addr      <= '0;
      entries_in_row <= '0;
      touched_count  <= '0;
      stored_count   <= '0;
      overflow_seen  <= 1'b0;
      scan           <= '0;
      fan            <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        smpre_pkg::StInit: init_addr <= init_addr + 1'b1;
        smpre_pkg::StIdle:
          if (accept) begin
            cur_inner <= inner_index;
            cur_value <= entry_value;
            fan       <= '0;
            scan      <= '0;
            if (smpre_pkg::action_t'(action) == smpre_pkg::ActStart) begin
              stored_count  <= '0;
              overflow_seen <= 1'b0;
            end
          end
        smpre_pkg::StFanRead:
          if (fan >= b_eff) begin
            if (entries_in_row + 4'd1 >= 4'(a_eff)) entries_in_row <= '0;
            else entries_in_row <= entries_in_row + 4'd1;
          end
        smpre_pkg::StFanWrite: begin
          fan <= fan + 1'b1;
          if (touch_we) touched_count <= touched_count + 1'b1;
        end
        smpre_pkg::StGatherRead:
          if (scan >= touched_count) scan <= '0;
        smpre_pkg::StGatherWait: begin
          out_column  <= touch_rd;
          kept        <= row_kept;
          last_of_row <= (scan + 1'b1 == touched_count);
          if (row_kept) begin
            stored_count <= stored_count + 1'b1;
            nnz_total    <= stored_count + 1'b1;
            overflow_flag <= overflow_seen;
          end else begin
            overflow_seen <= 1'b1;
            nnz_total     <= stored_count;
            overflow_flag <= 1'b1;
          end
        end
        smpre_pkg::StOut:
          if (out_ready) scan <= scan + 1'b1;
        smpre_pkg::StClearRead:
          if (scan >= touched_count) begin
            touched_count  <= '0;
            entries_in_row <= '0;
            scan           <= '0;
          end
        smpre_pkg::StClear: scan <= scan + 1'b1;
        default: ;
      endcase
    end
  end

  // The accumulator read for the gather lands in the first StOut cycle and is
  // held from then on while the beat waits.
  logic first_out;
  always_ff @(posedge clk) begin
    if (rst) first_out <= 1'b0;
    else first_out <= (state == smpre_pkg::StGatherWait);
  end
  logic [smpre_pkg::AccW-1:0] val_hold;
  always_ff @(posedge clk) begin
    if (first_out) val_hold <= acc_rd[smpre_pkg::AccW-1:0];
  end
  assign out_value = first_out ? acc_rd[smpre_pkg::AccW-1:0] : val_hold;

endmodule
